// ===== rtl/qse_pkg.sv =====
package qse_pkg;

    // One pin sample or one timestamp sample
    typedef struct packed {
        logic        mode;
        logic        pin_a;
        logic        pin_b;
        logic [15:0] time_us;
    } sample_t;

    // One result word
    typedef struct packed {
        logic signed [31:0] position;
        logic               speed_updated;
        logic signed [31:0] raw_speed;
        logic signed [31:0] filtered_speed;
    } result_t;

    // Classified work passed from front to back
    typedef struct packed {
        logic signed [31:0] position;
        logic               close;
        logic signed [15:0] delta;
        logic [15:0]        elapsed;
    } cmd_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Input mode codes
    localparam logic ModePin  = 1'b0;
    localparam logic ModeTime = 1'b1;

    // Configuration register indexes
    localparam logic CfgWindowUs      = 1'b0;
    localparam logic CfgSmoothingGain = 1'b1;

    localparam logic [15:0] WindowUsReset      = 16'd1415;
    localparam logic [15:0] SmoothingGainReset = 16'd6554;

    // Counts per second per count per microsecond
    localparam logic [19:0] ScaleCount = 20'd1000000;

    // Dividend width: 32768 * 1e6 < 2**35
    localparam int QuotW    = 35;
    localparam int DivSteps = QuotW;
    localparam int DivCntW  = 6;

endpackage

// ===== rtl/qse_front.sv =====
module qse_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qse_pkg::sample_t  sample,
    input  logic [15:0]       window_us,
    input  qse_pkg::qstat_t   qstat,
    output logic              q_push,
    output qse_pkg::cmd_t     cmd
);

    logic [31:0] position_reg, position_next;
    logic        prev_a_reg, prev_a_next;
    logic        prev_b_reg, prev_b_next;
    logic [15:0] win_start_reg, win_start_next;
    logic [15:0] win_pos_reg, win_pos_next;

    logic        fwd;
    logic        bwd;
    logic [15:0] elapsed;
    logic [15:0] need;
    logic        close;

    assign q_push = push && !qstat.full;

    // x4 decode and window check
    always_comb
    begin
        position_next  = position_reg;
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        win_start_next = win_start_reg;
        win_pos_next   = win_pos_reg;
        fwd            = sample.pin_a ^ prev_b_reg;
        bwd            = prev_a_reg ^ sample.pin_b;
        elapsed        = sample.time_us - win_start_reg;
        need           = (window_us == 16'd0) ? 16'd1 : window_us;
        close          = 1'b0;
        if (sample.mode == qse_pkg::ModePin)
        begin
            if (fwd && !bwd)
                position_next = position_reg + 32'd1;
            else if (!fwd && bwd)
                position_next = position_reg - 32'd1;
            prev_a_next = sample.pin_a;
            prev_b_next = sample.pin_b;
        end
        else if (elapsed >= need)
        begin
            close          = 1'b1;
            win_start_next = sample.time_us;
            win_pos_next   = position_reg[15:0];
        end
    end

    // Word handed to the back end
    always_comb
    begin
        cmd.position = $signed(position_next);
        cmd.close    = close;
        cmd.delta    = $signed(position_reg[15:0] - win_pos_reg);
        cmd.elapsed  = elapsed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            prev_a_reg    <= 1'b0;
            prev_b_reg    <= 1'b0;
            win_start_reg <= '0;
            win_pos_reg   <= '0;
        end
        else if (q_push)
        begin
            position_reg  <= position_next;
            prev_a_reg    <= prev_a_next;
            prev_b_reg    <= prev_b_next;
            win_start_reg <= win_start_next;
            win_pos_reg   <= win_pos_next;
        end
    end

endmodule

// ===== rtl/qse_queue.sv =====
module qse_queue #(
    parameter int Depth = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  qse_pkg::cmd_t   wr_data,
    input  logic            rd,
    output qse_pkg::cmd_t   rd_data,
    output qse_pkg::qstat_t qstat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    qse_pkg::cmd_t   mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == CntW'(Depth));
    assign qstat.empty = (count_reg == '0);
    assign rd_data     = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/qse_back.sv =====
module qse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  qse_pkg::qstat_t  qstat,
    input  qse_pkg::cmd_t    cmd,
    output logic             q_pop,
    input  logic [15:0]      smoothing_gain,
    input  logic             pop,
    output logic             empty,
    output qse_pkg::result_t result
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCALE = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_SAT   = 8'b0000_1000,
        S_FLO   = 8'b0001_0000,
        S_FHI   = 8'b0010_0000,
        S_FSUM  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [31:0]         pos_reg, pos_next;
    logic                       close_reg, close_next;
    logic                       neg_reg, neg_next;
    logic [15:0]                mag_reg, mag_next;
    logic [15:0]                den_reg, den_next;
    logic [qse_pkg::QuotW-1:0]  num_reg, num_next;
    logic [15:0]                rem_reg, rem_next;
    logic [qse_pkg::DivCntW-1:0] cnt_reg, cnt_next;
    logic signed [31:0]         raw_reg, raw_next;
    logic signed [47:0]         acc_reg, acc_next;
    logic signed [48:0]         diff_reg, diff_next;
    logic signed [42:0]         plo_reg, plo_next;
    logic signed [42:0]         phi_reg, phi_next;
    qse_pkg::result_t           res_reg, res_next;
    logic                       res_valid_reg, res_valid_next;

    logic [35:0]        scaled;
    logic [16:0]        shifted;
    logic               qbit;
    logic signed [31:0] sat;
    logic signed [25:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [42:0] mul_p;
    logic signed [67:0] sum;

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    // Shared filter multiplier, one half of the difference per step
    always_comb
    begin
        mul_b = $signed({1'b0, smoothing_gain});
        if (state_reg == S_FLO)
            mul_a = $signed({1'b0, diff_reg[24:0]});
        else
            mul_a = $signed({{2{diff_reg[48]}}, diff_reg[48:25]});
        mul_p = mul_a * mul_b;
    end

    // Datapath pieces
    always_comb
    begin
        scaled  = mag_reg * qse_pkg::ScaleCount;
        shifted = {rem_reg, num_reg[qse_pkg::QuotW-1]};
        qbit    = (shifted >= {1'b0, den_reg});
        if (!neg_reg)
            sat = (num_reg[qse_pkg::QuotW-1:31] != '0) ? 32'sh7FFF_FFFF
                                                      : $signed(num_reg[31:0]);
        else
            sat = (num_reg[qse_pkg::QuotW-1:31] != '0) ? 32'sh8000_0000
                                                      : $signed(-num_reg[31:0]);
        sum = ($signed({phi_reg, 25'd0})) + 68'(plo_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        close_next     = close_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        raw_next       = raw_reg;
        acc_next       = acc_reg;
        diff_next      = diff_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        q_pop          = 1'b0;

        if (pop && res_valid_reg)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    q_pop      = 1'b1;
                    pos_next   = cmd.position;
                    close_next = cmd.close;
                    neg_next   = cmd.delta[15];
                    mag_next   = cmd.delta[15] ? 16'(-cmd.delta) : 16'(cmd.delta);
                    den_next   = cmd.elapsed;
                    state_next = cmd.close ? S_SCALE : S_EMIT;
                end
            end
            S_SCALE:
            begin
                num_next   = scaled[qse_pkg::QuotW-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit a cycle
                rem_next = qbit ? 16'(shifted - {1'b0, den_reg}) : shifted[15:0];
                num_next = {num_reg[qse_pkg::QuotW-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == qse_pkg::DivCntW'(qse_pkg::DivSteps - 1))
                    state_next = S_SAT;
            end
            S_SAT:
            begin
                raw_next   = sat;
                diff_next  = $signed({sat, 16'd0}) - 49'(acc_reg);
                state_next = S_FLO;
            end
            S_FLO:
            begin
                plo_next   = mul_p;
                state_next = S_FHI;
            end
            S_FHI:
            begin
                phi_next   = mul_p;
                state_next = S_FSUM;
            end
            S_FSUM:
            begin
                // Step is floor(diff * gain / 65536)
                acc_next   = acc_reg + $signed(sum[63:16]);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_next.position       = pos_reg;
                    res_next.speed_updated  = close_reg;
                    res_next.raw_speed      = raw_reg;
                    res_next.filtered_speed = acc_reg[47:16];
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            raw_reg       <= '0;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            raw_reg       <= raw_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        close_reg <= close_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        diff_reg  <= diff_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        res_reg   <= res_next;
    end

endmodule

// ===== rtl/quadrature_speed_estimator.sv =====
// Channel   Handshake          Word
// sample    push / full        qse_pkg::sample_t (pin sample or timestamp)
// result    pop / empty        qse_pkg::result_t (one per sample, in order)
// config    cfg_valid/ready    cfg_index selects window_us or smoothing_gain
//
// A pin sample or a timestamp that leaves the window open passes the queue
// and the back end's idle and emit states; one that closes a window also
// passes scaling, the 35-step restoring divider, saturation and the two-step
// filter multiply and sum. Reset clears control and filter state at once,
// not payload storage; no clearing pass. QueueDepth samples are taken while
// the back end is busy; a held result stalls it only at its result register.
module quadrature_speed_estimator #(
    parameter int QueueDepth = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  qse_pkg::sample_t sample,
    output logic             empty,
    input  logic             pop,
    output qse_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data
);

    logic [15:0]     window_us_reg;
    logic [15:0]     gain_reg;
    logic            q_push;
    logic            q_pop;
    qse_pkg::cmd_t   cmd_in;
    qse_pkg::cmd_t   cmd_out;
    qse_pkg::qstat_t qstat;

    assign cfg_ready = 1'b1;
    assign full      = qstat.full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_us_reg <= qse_pkg::WindowUsReset;
            gain_reg      <= qse_pkg::SmoothingGainReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qse_pkg::CfgWindowUs:      window_us_reg <= cfg_data;
                qse_pkg::CfgSmoothingGain: gain_reg      <= cfg_data;
                default:                   window_us_reg <= window_us_reg;
            endcase
        end
    end

    qse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample    (sample),
        .window_us (window_us_reg),
        .qstat     (qstat),
        .q_push    (q_push),
        .cmd       (cmd_in)
    );

    qse_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (cmd_in),
        .rd      (q_pop),
        .rd_data (cmd_out),
        .qstat   (qstat)
    );

    qse_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .qstat          (qstat),
        .cmd            (cmd_out),
        .q_pop          (q_pop),
        .smoothing_gain (gain_reg),
        .pop            (pop),
        .empty          (empty),
        .result         (result)
    );

    // Back end never takes from an empty queue
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !qstat.empty)
        else $error("queue read while empty");

    // Front end never writes a full queue
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !qstat.full)
        else $error("queue written while full");

    // Only a timestamp sample closes a window
    a_close_is_time : assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && cmd_in.close) |-> (sample.mode == qse_pkg::ModeTime))
        else $error("window closed by a pin sample");

endmodule

// ===== test/qse_result_check.sv =====
`timescale 1ns / 1ps

module qse_result_check (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  qse_pkg::sample_t sample,
    input  logic             empty,
    input  logic             pop,
    input  qse_pkg::result_t result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    output int               errors,
    output int               pending,
    output int               words_checked,
    output int               windows_closed
);

    localparam logic signed [63:0] CountsPerSecond = 64'sd1000000;
    localparam logic signed [63:0] SpeedMax        = 64'sd2147483647;
    localparam logic signed [63:0] SpeedMin        = -64'sd2147483648;
    localparam logic signed [63:0] QOne            = 64'sd65536;

    // Predicted estimator state
    logic [31:0]        pos_cnt;
    logic               last_a;
    logic               last_b;
    logic [15:0]        win_start;
    logic [15:0]        win_pos;
    logic signed [31:0] speed_raw;
    logic signed [63:0] lp_acc;     // Q32.16
    logic [15:0]        win_len;
    logic [15:0]        gain;

    qse_pkg::result_t due_results[$];
    int               n_taken;
    int               n_seen;
    int               n_bad;
    int               n_closed;

    // Apply one sample word to the predicted state, return the result word
    function automatic qse_pkg::result_t estimate(input qse_pkg::sample_t s);
        qse_pkg::result_t   r;
        logic               up;
        logic               down;
        logic [15:0]        elapsed;
        logic [15:0]        need;
        logic [15:0]        d16;
        logic signed [63:0] delta;
        logic signed [63:0] spd;
        logic signed [63:0] diff;
        logic signed [63:0] dh;
        logic signed [63:0] dl;
        logic signed [63:0] gain_q;
        logic signed [63:0] flt;
        r.speed_updated = 1'b0;
        if (s.mode == qse_pkg::ModePin) begin
            // x4 decode; a double step leaves the count alone
            up   = s.pin_a ^ last_b;
            down = last_a ^ s.pin_b;
            if (up && !down)
                pos_cnt = pos_cnt + 32'd1;
            else if (!up && down)
                pos_cnt = pos_cnt - 32'd1;
            last_a = s.pin_a;
            last_b = s.pin_b;
        end
        else begin
            elapsed = s.time_us - win_start;
            need    = (win_len == 16'd0) ? 16'd1 : win_len;
            if (elapsed >= need) begin
                // window delta wraps to 16 bits, speed saturates to 32
                d16   = pos_cnt[15:0] - win_pos;
                delta = $signed(d16);
                spd   = delta * CountsPerSecond / $signed({48'd0, elapsed});
                if (spd > SpeedMax)
                    spd = SpeedMax;
                else if (spd < SpeedMin)
                    spd = SpeedMin;
                win_start = s.time_us;
                win_pos   = pos_cnt[15:0];
                speed_raw = spd[31:0];
                // low-pass step, gain split over floor and fraction of diff
                gain_q = $signed({48'd0, gain});
                diff   = (spd <<< 16) - lp_acc;
                dh     = diff >>> 16;
                dl     = diff - (dh <<< 16);
                lp_acc = lp_acc + dh * gain_q + (dl * gain_q) / QOne;
                r.speed_updated = 1'b1;
                n_closed++;
            end
        end
        flt              = lp_acc >>> 16;
        r.position       = pos_cnt;
        r.raw_speed      = speed_raw;
        r.filtered_speed = flt[31:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
            n_bad++;
        end
    endtask

    // Watch config, sample and result channels
    always @(posedge clk or negedge rst_n) begin : watch
        qse_pkg::result_t want;
        if (!rst_n) begin
            pos_cnt   = '0;
            last_a    = 1'b0;
            last_b    = 1'b0;
            win_start = '0;
            win_pos   = '0;
            speed_raw = '0;
            lp_acc    = '0;
            win_len   = qse_pkg::WindowUsReset;
            gain      = qse_pkg::SmoothingGainReset;
            due_results.delete();
            n_taken   = 0;
            n_seen    = 0;
            n_bad     = 0;
            n_closed  = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == qse_pkg::CfgWindowUs)
                    win_len = cfg_data;
                else
                    gain = cfg_data;
            end
            if (push && !full) begin
                due_results.push_back(estimate(sample));
                n_taken++;
            end
            if (pop && !empty) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result word with none expected: expected none actual %h",
                             $time, result);
                    n_bad++;
                end
                else begin
                    want = due_results.pop_front();
                    check_field("position", want.position, result.position);
                    check_field("speed_updated", want.speed_updated, result.speed_updated);
                    check_field("raw_speed", want.raw_speed, result.raw_speed);
                    check_field("filtered_speed", want.filtered_speed, result.filtered_speed);
                    n_seen++;
                end
            end
        end
        errors         <= n_bad;
        pending        <= n_taken - n_seen;
        words_checked  <= n_seen;
        windows_closed <= n_closed;
    end

endmodule

// ===== test/quadrature_speed_estimator_test.sv =====
`timescale 1ns / 1ps

module quadrature_speed_estimator_test;

    localparam int CycleLimit  = 2000000;
    localparam int PhaseWords  = 160;
    localparam int SpinSteps   = 200;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             push;
    logic             full;
    qse_pkg::sample_t sample;
    logic             empty;
    logic             pop = 1'b0;
    qse_pkg::result_t result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [15:0]      cfg_data;

    int errors;
    int pending;
    int words_checked;
    int windows_closed;

    // Stimulus bookkeeping
    logic [1:0]  gray_idx = 2'd0;   // encoder phase the block last saw
    logic [15:0] clock_us = 16'd0;  // last timestamp sent
    logic [15:0] cur_window = qse_pkg::WindowUsReset;
    int          burst_left = 0;
    int          words_sent = 0;
    int          setting_count = 0;
    int          cycle_count = 0;

    always #5 clk = ~clk;

    quadrature_speed_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qse_result_check speed_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .sample         (sample),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending),
        .words_checked  (words_checked),
        .windows_closed (windows_closed)
    );

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("quadrature_speed_estimator verification failed");
            $finish;
        end
    end

    // Result side: stall style changes every so often
    int pop_mode = 0;
    int mode_left = 0;
    int stall_left = 0;
    always @(posedge clk) begin
        if (mode_left == 0) begin
            pop_mode  = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_left > 0) begin
                    stall_left--;
                    pop <= 1'b0;
                end
                else begin
                    pop <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(4, 20);
                end
            end
        endcase
    end

    // Offer one sample word in bursts with random gaps
    task automatic offer_word(input qse_pkg::sample_t s);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 24);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full) @(posedge clk);
        words_sent++;
    endtask

    // Send a word and keep the encoder phase and clock in step with it
    task automatic send_raw(input qse_pkg::sample_t s);
        if (s.mode == qse_pkg::ModePin)
            gray_idx = {s.pin_b, s.pin_a ^ s.pin_b};
        else
            clock_us = s.time_us;
        offer_word(s);
    endtask

    task automatic send_pins(input logic a, input logic b);
        qse_pkg::sample_t s;
        s.mode    = qse_pkg::ModePin;
        s.pin_a   = a;
        s.pin_b   = b;
        s.time_us = 16'($urandom);
        send_raw(s);
    endtask

    task automatic stamp(input logic [15:0] t);
        qse_pkg::sample_t s;
        s.mode    = qse_pkg::ModeTime;
        s.pin_a   = 1'($urandom_range(0, 1));
        s.pin_b   = 1'($urandom_range(0, 1));
        s.time_us = t;
        send_raw(s);
    endtask

    // Move the encoder by dir quarter steps (2 is an illegal double step)
    task automatic turn(input int dir);
        logic [1:0] nxt;
        nxt = gray_idx + dir[1:0];
        send_pins(nxt[0] ^ nxt[1], nxt[1]);
    endtask

    function automatic qse_pkg::sample_t random_word();
        qse_pkg::sample_t s;
        s.mode    = 1'($urandom_range(0, 1));
        s.pin_a   = 1'($urandom_range(0, 1));
        s.pin_b   = 1'($urandom_range(0, 1));
        s.time_us = 16'($urandom);
        return s;
    endfunction

    // Stop sending and wait until every result word has been checked
    task automatic wait_for_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] win, input logic [15:0] g);
        wait_for_results();
        write_reg(qse_pkg::CfgWindowUs, win);
        write_reg(qse_pkg::CfgSmoothingGain, g);
        cfg_valid <= 1'b0;
        cur_window = win;
        setting_count++;
    endtask

    // Steady turning with timestamps paced around the window length
    task automatic run_walk();
        int dir;
        int len;
        int span;
        dir  = ($urandom_range(0, 1) == 1) ? 1 : -1;
        len  = $urandom_range(4, 40);
        span = (cur_window == 16'd0) ? 1 : int'(cur_window);
        repeat (len) begin
            case ($urandom_range(0, 9))
                0, 1: stamp(clock_us + 16'($urandom_range(0, span / 2 + 1)));
                2: stamp(clock_us + 16'($urandom));
                3: turn(-dir);
                default: turn(dir);
            endcase
        end
    endtask

    // Double steps, repeated levels and timestamps that step back
    task automatic run_glitches();
        repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 3))
                0: turn(2);
                1: turn(0);
                2: stamp(clock_us - 16'($urandom_range(1, 64)));
                default: turn(($urandom_range(0, 1) == 1) ? 1 : -1);
            endcase
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(2, 10)) send_raw(random_word());
    endtask

    initial begin
        int          phase_end;
        logic [15:0] base;
        rst_n     = 1'b0;
        push      = 1'b0;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = qse_pkg::CfgWindowUs;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: forward, backward, hold, double step, window edges
        stamp(16'd0);
        send_pins(1'b1, 1'b0);
        send_pins(1'b1, 1'b1);
        send_pins(1'b0, 1'b1);
        send_pins(1'b0, 1'b0);
        send_pins(1'b0, 1'b1);
        send_pins(1'b1, 1'b1);
        send_pins(1'b1, 1'b1);
        send_pins(1'b0, 1'b0);
        stamp(16'd1414);
        stamp(16'd1415);
        send_pins(1'b1, 1'b0);
        stamp(16'hFFFF);
        send_pins(1'b0, 1'b0);
        stamp(16'h0010);
        stamp(16'd1414);

        // Zero window acts as one microsecond, full gain
        apply_setting(16'd0, 16'hFFFF);
        stamp(clock_us);
        repeat (3) turn(1);
        stamp(clock_us + 16'd1);

        // Longest window closes only at the full wrap, zero gain
        apply_setting(16'hFFFF, 16'd0);
        base = clock_us;
        stamp(base - 16'd2);
        stamp(base - 16'd1);

        // Fast spins in both directions over a one microsecond window
        apply_setting(16'd1, 16'hFFFF);
        repeat (SpinSteps) turn(1);
        stamp(clock_us + 16'd1);
        repeat (SpinSteps) turn(-1);
        stamp(clock_us + 16'd1);

        // Random traffic under several settings
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: apply_setting(qse_pkg::WindowUsReset, qse_pkg::SmoothingGainReset);
                1: apply_setting(16'd1, 16'hFFFF);
                2: apply_setting(16'd0, 16'd0);
                3: apply_setting(16'hFFFF, 16'h8000);
                4: apply_setting(16'($urandom_range(1, 4000)), 16'($urandom));
                default: apply_setting(16'($urandom), 16'($urandom));
            endcase
            phase_end = words_sent + PhaseWords;
            while (words_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    7, 8: run_noise();
                    9: run_glitches();
                    default: run_walk();
                endcase
            end
        end

        wait_for_results();
        repeat (60) @(posedge clk);

        $display("Sent %0d sample words, checked %0d result words, %0d speed windows closed,",
                 words_sent, words_checked, windows_closed);
        $display("across %0d register settings including fast spins.", setting_count);
        if (errors == 0)
            $display("quadrature_speed_estimator verification clean");
        else
            $display("quadrature_speed_estimator verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/qse_pkg.sv
rtl/qse_front.sv
rtl/qse_queue.sv
rtl/qse_back.sv
rtl/quadrature_speed_estimator.sv
test/qse_result_check.sv
test/quadrature_speed_estimator_test.sv
